// ===== sv/bmftl_pkg.sv =====
// ----------------------------------------------------------------------------
// bmftl_pkg
// Shared types and default sizes of the block-mapping translation layer.
// ----------------------------------------------------------------------------
package bmftl_pkg;

    localparam int PAGES_IN_BLOCK_DEF = 8;
    localparam int DATA_BLOCKS_DEF    = 15;
    localparam int TOTAL_BLOCKS_DEF   = 16;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_READ    = 3'd1,
        CMD_PROGRAM = 3'd2,
        CMD_COPY    = 3'd3,
        CMD_ERASE   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } t_action;

endpackage

// ===== sv/bmftl_ram.sv =====
// ----------------------------------------------------------------------------
// bmftl_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
module bmftl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/block_mapping_ftl.sv =====
// ----------------------------------------------------------------------------
// block_mapping_ftl
// Sequence: a range error is answered from S_DIV, a read from S_ROW after
//   the map read, an in-place program from S_DECIDE after the page-row read,
//   a merge as one copy or program per page from S_MERGE and then an erase.
// One request at a time, one command per cycle while the output is not
//   stalled. Reset: a clearing pass unmaps all blocks and clears all written
//   bits; no request is taken until it ends.
// ----------------------------------------------------------------------------
module block_mapping_ftl #(
    parameter int PAGES_IN_BLOCK = bmftl_pkg::PAGES_IN_BLOCK_DEF,
    parameter int DATA_BLOCKS    = bmftl_pkg::DATA_BLOCKS_DEF,
    parameter int TOTAL_BLOCKS   = bmftl_pkg::TOTAL_BLOCKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [0:0]           i_action,
    input  logic [6:0]           i_lsn,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bmftl_pkg::t_cmd      o_command,
    output logic [6:0]           o_page,
    output logic [6:0]           o_source_page,
    output logic [3:0]           o_spare_tag,
    output bmftl_pkg::t_status   o_status,
    output logic                 o_last
);

    import bmftl_pkg::*;

    localparam int ALL_PAGES = PAGES_IN_BLOCK * TOTAL_BLOCKS;
    localparam int PW = $clog2(ALL_PAGES);
    localparam int BW = $clog2(TOTAL_BLOCKS);
    localparam int LW = (DATA_BLOCKS > 1) ? $clog2(DATA_BLOCKS) : 1;
    localparam int OW = (PAGES_IN_BLOCK > 1) ? $clog2(PAGES_IN_BLOCK) : 1;
    localparam int SH = 14;
    localparam int RW = 15;
    localparam int PRW = 7 + RW;
    localparam int RECIP = ((1 << SH) + PAGES_IN_BLOCK - 1) / PAGES_IN_BLOCK;
    localparam logic [RW-1:0] RECIP_W = RW'(RECIP);
    localparam logic [14:0] LIMIT_W = 15'(PAGES_IN_BLOCK * DATA_BLOCKS);
    localparam logic [6:0] PIB_7 = 7'(PAGES_IN_BLOCK);
    localparam logic [PW-1:0] PIB_P = PW'(PAGES_IN_BLOCK);
    localparam logic [OW-1:0] LAST_OFF = OW'(PAGES_IN_BLOCK - 1);
    localparam logic [BW-1:0] LAST_ROW = BW'(TOTAL_BLOCKS - 1);
    localparam logic [BW-1:0] FREE_RST = BW'(DATA_BLOCKS);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_MAP    = 8'b0000_1000,
        S_ROW    = 8'b0001_0000,
        S_DECIDE = 8'b0010_0000,
        S_MERGE  = 8'b0100_0000,
        S_ERASE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [BW-1:0] r_clr, n_clr;
    logic [BW-1:0] r_free, n_free;
    logic [0:0]    r_action;
    logic [6:0]    r_lsn;
    logic [6:0]    r_q, n_q;
    logic [LW-1:0] r_lbn, n_lbn;
    logic [OW-1:0] r_off, n_off;
    logic [OW-1:0] r_i, n_i;
    logic [BW-1:0] r_pbn, n_pbn;
    logic [PW-1:0] r_pbn_base, n_pbn_base;
    logic [PW-1:0] r_fb_base, n_fb_base;

    logic          r_out_valid;
    t_cmd          r_cmd;
    logic [6:0]    r_page, r_src;
    logic [3:0]    r_tag;
    t_status       r_status;
    logic          r_last;

    logic          in_accept;
    logic          out_free;
    logic          emit;
    t_cmd          e_cmd;
    logic [6:0]    e_page, e_src;
    logic [3:0]    e_tag;
    t_status       e_status;
    logic          e_last;

    logic [PRW-1:0] prod;
    logic [6:0]     off_full;

    logic                  bm_we, bm_re;
    logic [LW-1:0]         bm_waddr, bm_raddr;
    logic [BW:0]           bm_wdata, bm_rdata;
    logic                  row_we, row_re;
    logic [BW-1:0]         row_waddr, row_raddr;
    logic [PAGES_IN_BLOCK-1:0] row_wdata, row_rdata;

    bmftl_ram #(.WIDTH(BW + 1), .DEPTH(DATA_BLOCKS), .AW(LW)) u_map (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    bmftl_ram #(.WIDTH(PAGES_IN_BLOCK), .DEPTH(TOTAL_BLOCKS), .AW(BW)) u_rows (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign prod       = PRW'(r_lsn) * PRW'(RECIP_W);
    assign off_full   = r_lsn - 7'(r_q * PIB_7);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_free     = r_free;
        n_q        = r_q;
        n_lbn      = r_lbn;
        n_off      = r_off;
        n_i        = r_i;
        n_pbn      = r_pbn;
        n_pbn_base = r_pbn_base;
        n_fb_base  = r_fb_base;
        emit       = 1'b0;
        e_cmd      = CMD_NONE;
        e_page     = '0;
        e_src      = '0;
        e_tag      = '0;
        e_status   = ST_OK;
        e_last     = 1'b0;
        bm_we      = 1'b0;
        bm_waddr   = r_lbn;
        bm_wdata   = '0;
        bm_re      = 1'b0;
        bm_raddr   = r_q[LW-1:0];
        row_we     = 1'b0;
        row_waddr  = r_pbn;
        row_wdata  = '0;
        row_re     = 1'b0;
        row_raddr  = r_pbn;
        if (LW > 7) begin
            bm_raddr = LW'(r_q);
        end
        unique case (r_state)
            S_CLEAR: begin
                row_we    = 1'b1;
                row_waddr = r_clr;
                if (32'(r_clr) < DATA_BLOCKS) begin
                    bm_we    = 1'b1;
                    bm_waddr = LW'(r_clr);
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (15'(r_lsn) >= LIMIT_W) begin
                    e_status = ST_RANGE;
                    e_last   = 1'b1;
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_q     = 7'(prod >> SH);
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                bm_re   = 1'b1;
                n_lbn   = LW'(r_q);
                n_off   = OW'(off_full);
                n_state = S_ROW;
            end
            S_ROW: begin
                n_pbn      = bm_rdata[BW] ? bm_rdata[BW-1:0] : BW'(r_lbn);
                n_pbn_base = PW'(PW'(n_pbn) * PIB_P);
                if (r_action == ACT_READ) begin
                    e_last = 1'b1;
                    if (bm_rdata[BW]) begin
                        e_cmd  = CMD_READ;
                        e_page = 7'(n_pbn_base + PW'(r_off));
                    end else begin
                        e_status = ST_UNMAPPED;
                    end
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (!bm_rdata[BW]) begin
                        bm_we    = 1'b1;
                        bm_wdata = {1'b1, BW'(r_lbn)};
                    end
                    row_re    = 1'b1;
                    row_raddr = n_pbn;
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!row_rdata[r_off]) begin
                    e_cmd  = CMD_PROGRAM;
                    e_page = 7'(r_pbn_base + PW'(r_off));
                    e_tag  = 4'(r_lbn);
                    e_last = 1'b1;
                    if (out_free) begin
                        emit      = 1'b1;
                        row_we    = 1'b1;
                        row_wdata = row_rdata | (PAGES_IN_BLOCK'(1) << r_off);
                        n_state   = S_IDLE;
                    end
                end else begin
                    row_we    = 1'b1;
                    row_waddr = r_free;
                    row_wdata = row_rdata | (PAGES_IN_BLOCK'(1) << r_off);
                    n_fb_base = PW'(PW'(r_free) * PIB_P);
                    n_i       = '0;
                    n_state   = S_MERGE;
                end
            end
            S_MERGE: begin
                e_page = 7'(r_fb_base + PW'(r_i));
                e_tag  = 4'(r_lbn);
                if (r_i == r_off) begin
                    e_cmd = CMD_PROGRAM;
                end else begin
                    e_cmd = CMD_COPY;
                    e_src = 7'(r_pbn_base + PW'(r_i));
                end
                if (out_free) begin
                    emit = 1'b1;
                    n_i  = r_i + 1'b1;
                    if (r_i == LAST_OFF) begin
                        n_state = S_ERASE;
                    end
                end
            end
            S_ERASE: begin
                e_cmd  = CMD_ERASE;
                e_page = 7'(r_pbn);
                e_last = 1'b1;
                if (out_free) begin
                    emit     = 1'b1;
                    row_we   = 1'b1;
                    bm_we    = 1'b1;
                    bm_wdata = {1'b1, r_free};
                    n_free   = r_pbn;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free      <= FREE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_free  <= n_free;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= i_action;
            r_lsn    <= i_lsn;
        end
        r_q        <= n_q;
        r_lbn      <= n_lbn;
        r_off      <= n_off;
        r_i        <= n_i;
        r_pbn      <= n_pbn;
        r_pbn_base <= n_pbn_base;
        r_fb_base  <= n_fb_base;
        if (emit) begin
            r_cmd    <= e_cmd;
            r_page   <= e_page;
            r_src    <= e_src;
            r_tag    <= e_tag;
            r_status <= e_status;
            r_last   <= e_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_command     = r_cmd;
    assign o_page        = r_page;
    assign o_source_page = r_src;
    assign o_spare_tag   = r_tag;
    assign o_status      = r_status;
    assign o_last        = r_last;

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("request taken during clearing pass");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_DIV))
        else $error("accepted request did not start decoding");

    a_merge_ends_in_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE && emit && r_i == LAST_OFF) |=> (r_state == S_ERASE))
        else $error("merge did not end with an erase");

    a_free_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERASE && out_free) |=> (r_free == $past(r_pbn)))
        else $error("erased block did not become the free block");

    a_merge_old_not_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (r_pbn != r_free))
        else $error("merge source equals free block");

endmodule

// ===== tb/block_mapping_ftl_tb.sv =====
// ----------------------------------------------------------------------------
// block_mapping_ftl_tb
// Self-checking bench for the block-mapping translation layer. Host read and
// write requests go in through a queue-fed driver; a scoreboard keeps its own
// copy of the block map, the spare block and the per-page written bits, works
// out the flash commands each accepted request should produce, and checks the
// command stream field by field. Both sides idle at random, and the receiver
// holds off once for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module block_mapping_ftl_tb;
    import bmftl_pkg::*;

    localparam int PIB       = PAGES_IN_BLOCK_DEF;
    localparam int DB        = DATA_BLOCKS_DEF;
    localparam int TB        = TOTAL_BLOCKS_DEF;
    localparam int ALL_PAGES = PIB * TB;
    localparam int SECTORS   = PIB * DB;
    localparam int N_RANDOM  = 420;
    localparam int LIMIT     = 600000;
    localparam int DRAIN     = 40;
    localparam int HOLD_AT   = 60;
    localparam int HOLD_LEN  = 250;

    typedef struct packed {
        t_action    act;
        logic [6:0] lsn;
    } t_host_req;

    typedef struct packed {
        t_cmd       command;
        logic [6:0] page;
        logic [6:0] source_page;
        logic [3:0] spare_tag;
        t_status    status;
        logic       last;
    } t_flash_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [0:0]  i_action = 1'b0;
    logic [6:0]  i_lsn = 7'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_cmd        o_command;
    logic [6:0]  o_page;
    logic [6:0]  o_source_page;
    logic [3:0]  o_spare_tag;
    t_status     o_status;
    logic        o_last;

    // scoreboard copy of the translation state
    logic [3:0]  l2p_blk [DB];
    logic        l2p_valid [DB];
    logic [3:0]  spare_blk;
    logic        pg_written [ALL_PAGES];

    t_host_req   host_reqs[$];
    t_flash_cmd  flash_cmds[$];
    t_flash_cmd  want;

    logic        in_taken = 1'b0;
    int          n_sent = 0;
    int          n_fail = 0;
    int          n_cycles = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          run_left = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic        calm;

    assign calm = (n_sent >= 200) && (n_sent < 260);

    block_mapping_ftl u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_lsn         (i_lsn),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_command     (o_command),
        .o_page        (o_page),
        .o_source_page (o_source_page),
        .o_spare_tag   (o_spare_tag),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [6:0] phys_page(int blk, int off);
        return 7'((blk * PIB + off) % ALL_PAGES);
    endfunction

    function automatic t_flash_cmd flash_cmd(t_cmd c, logic [6:0] page, logic [6:0] src,
                                             int tag, t_status st, logic last);
        t_flash_cmd f;
        f.command     = c;
        f.page        = page;
        f.source_page = src;
        f.spare_tag   = 4'(tag);
        f.status      = st;
        f.last        = last;
        return f;
    endfunction

    task automatic translate(t_action act, logic [6:0] lsn);
        int lbn, off, pbn, fb, i;
        logic [6:0] ppn, dst, src;
        if (lsn >= SECTORS) begin
            flash_cmds.push_back(flash_cmd(CMD_NONE, 0, 0, 0, ST_RANGE, 1'b1));
            return;
        end
        lbn = lsn / PIB;
        off = lsn % PIB;
        if (act == ACT_READ) begin
            if (!l2p_valid[lbn])
                flash_cmds.push_back(flash_cmd(CMD_NONE, 0, 0, 0, ST_UNMAPPED, 1'b1));
            else
                flash_cmds.push_back(flash_cmd(CMD_READ, phys_page(l2p_blk[lbn], off), 0, 0,
                                               ST_OK, 1'b1));
            return;
        end
        if (!l2p_valid[lbn]) begin
            l2p_blk[lbn]   = 4'(lbn);
            l2p_valid[lbn] = 1'b1;
        end
        pbn = l2p_blk[lbn];
        ppn = phys_page(pbn, off);
        if (!pg_written[ppn]) begin
            pg_written[ppn] = 1'b1;
            flash_cmds.push_back(flash_cmd(CMD_PROGRAM, ppn, 0, lbn, ST_OK, 1'b1));
            return;
        end
        // merge into the spare block, then erase the old one
        fb = spare_blk;
        for (i = 0; i < PIB; i++) begin
            dst = phys_page(fb, i);
            src = phys_page(pbn, i);
            if (i == off) begin
                pg_written[dst] = 1'b1;
                flash_cmds.push_back(flash_cmd(CMD_PROGRAM, dst, 0, lbn, ST_OK, 1'b0));
            end else begin
                pg_written[dst] = pg_written[src];
                flash_cmds.push_back(flash_cmd(CMD_COPY, dst, src, lbn, ST_OK, 1'b0));
            end
            pg_written[src] = 1'b0;
        end
        flash_cmds.push_back(flash_cmd(CMD_ERASE, 7'(pbn), 0, 0, ST_OK, 1'b1));
        l2p_blk[lbn] = 4'(fb);
        spare_blk    = 4'(pbn);
    endtask

    task automatic add_req(t_action act, int lsn);
        t_host_req r;
        r.act = act;
        r.lsn = 7'(lsn);
        host_reqs.push_back(r);
    endtask

    task automatic check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            n_fail++;
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (send_gap > 0) begin
                    i_in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (host_reqs.size() > 0) begin
                    i_action <= host_reqs[0].act;
                    i_lsn <= host_reqs[0].lsn;
                    host_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap <= calm ? 0 : gap_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && n_sent >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                i_out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (run_left > 0) begin
                run_left <= run_left - 1;
                i_out_stall <= 1'b0;
            end else begin
                stall_left <= gap_len();
                run_left <= $urandom_range(0, 10);
                i_out_stall <= 1'b0;
            end
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            translate(t_action'(i_action), i_lsn);
            n_sent <= n_sent + 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (flash_cmds.size() == 0) begin
                $error("unexpected transaction: command %0d page %0d", o_command, o_page);
                n_fail++;
            end else begin
                want = flash_cmds.pop_front();
                check_field("command", want.command, o_command);
                check_field("page", want.page, o_page);
                check_field("source_page", want.source_page, o_source_page);
                check_field("spare_tag", want.spare_tag, o_spare_tag);
                check_field("status", want.status, o_status);
                check_field("last", want.last, o_last);
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= LIMIT) begin
            $display("FAIL block_mapping_ftl");
            $finish;
        end
    end

    initial begin
        int i, n, lbn, off, r;
        for (i = 0; i < DB; i++) begin
            l2p_blk[i]   = 4'd0;
            l2p_valid[i] = 1'b0;
        end
        for (i = 0; i < ALL_PAGES; i++)
            pg_written[i] = 1'b0;
        spare_blk = 4'(DB);

        // directed: range errors, unmapped read, program, merges, block rotation
        add_req(ACT_READ, 127);
        add_req(ACT_WRITE, SECTORS);
        add_req(ACT_READ, 0);
        add_req(ACT_WRITE, 0);
        add_req(ACT_READ, 0);
        add_req(ACT_WRITE, 3);
        add_req(ACT_WRITE, 0);
        add_req(ACT_READ, 3);
        add_req(ACT_READ, 0);
        add_req(ACT_WRITE, 7);
        add_req(ACT_WRITE, 7);
        add_req(ACT_READ, 7);
        add_req(ACT_READ, SECTORS - 1);
        add_req(ACT_WRITE, SECTORS - 1);
        add_req(ACT_WRITE, SECTORS - 1);
        add_req(ACT_WRITE, SECTORS - PIB);
        add_req(ACT_READ, SECTORS - 1);
        add_req(ACT_WRITE, 85);
        add_req(ACT_WRITE, 85);
        add_req(ACT_WRITE, 80);
        add_req(ACT_WRITE, 0);
        add_req(ACT_READ, 85);
        add_req(ACT_WRITE, 127);

        // random: hot blocks and full-block bursts drive repeated merges
        n = 0;
        while (n < N_RANDOM) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                add_req(t_action'($urandom_range(0, 1)), $urandom_range(SECTORS, 127));
                n++;
            end else if (r < 12) begin
                lbn = $urandom_range(0, DB - 1);
                for (off = 0; off < PIB; off++)
                    add_req(ACT_WRITE, lbn * PIB + off);
                add_req(ACT_WRITE, lbn * PIB + $urandom_range(0, PIB - 1));
                n += PIB + 1;
            end else begin
                lbn = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, DB - 1);
                off = $urandom_range(0, PIB - 1);
                add_req(($urandom_range(0, 99) < 60) ? ACT_WRITE : ACT_READ, lbn * PIB + off);
                n++;
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (host_reqs.size() > 0 || i_in_valid)
            @(posedge i_clk);
        while (flash_cmds.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (n_fail == 0)
            $display("PASS block_mapping_ftl");
        else
            $display("FAIL block_mapping_ftl");
        $finish;
    end

endmodule
